// ===== hw/rtl/two_pkg.sv =====
`default_nettype none
package two_pkg;

  localparam int TrigIterations = 16;
  localparam int FracBits       = 16;
  localparam int MaxIter        = 24;
  localparam int DivQBits       = 34;

  localparam logic [15:0] FullTurn    = 16'd36000;
  localparam logic [15:0] HalfTurn    = 16'd18000;
  localparam logic [15:0] QuarterTurn = 16'd9000;
  localparam logic [31:0] PiQ30       = 32'd3373259426;
  localparam logic [31:0] InvGainQ30  = 32'd652032874;
  localparam logic [29:0] OffsetDen   = 30'd589824000;
  localparam logic [29:0] OffsetHalf  = 30'd294912000;

  typedef struct packed {
    logic        op;
    logic [15:0] heading_in;
    logic [31:0] vert_delta;
    logic [31:0] hori_delta;
    logic [31:0] new_x;
    logic [31:0] new_y;
  } two_in_t;

  typedef struct packed {
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [15:0] heading_out;
  } two_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ZDIV, S_TRIG, S_ODIV, S_ROT, S_FIN
  } two_state_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_SET    = 1'b1
  } two_op_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd843314856;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043836;
      5'd3:  a = 30'd133525158;
      5'd4:  a = 30'd67021686;
      5'd5:  a = 30'd33543515;
      5'd6:  a = 30'd16775850;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194282;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048575;
      5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;
      5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;
      5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;
      5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;
      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;
      5'd21: a = 30'd511;
      5'd22: a = 30'd255;
      5'd23: a = 30'd127;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/two_div.sv =====
`default_nettype none
module two_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [29:0] divisor,
  output logic             done,
  output logic [33:0]      quotient
);
  import two_pkg::*;

  logic [29:0] rem;
  logic [33:0] sh;
  logic [29:0] dsr;
  logic [5:0]  cnt;
  logic        run;
  logic [30:0] trial;
  logic        ge;

  assign trial = {rem, sh[DivQBits-1]} - {1'b0, dsr};
  assign ge    = {rem, sh[DivQBits-1]} >= {1'b0, dsr};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= dividend[63:DivQBits];
        sh  <= dividend[DivQBits-1:0];
        dsr <= divisor;
        cnt <= 6'(DivQBits);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? trial[29:0] : {rem[28:0], sh[DivQBits-1]};
        sh  <= {sh[DivQBits-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/two_cordic.sv =====
`default_nettype none
module two_cordic #(
  parameter int FRAC_BITS       = two_pkg::FracBits,
  parameter int TRIG_ITERATIONS = two_pkg::TrigIterations
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [32:0]              z0,
  input  wire logic                     flip,
  output logic                          done,
  output logic signed [FRAC_BITS+2:0]   sn,
  output logic signed [FRAC_BITS+2:0]   cs
);
  import two_pkg::*;

  localparam int CW = FRAC_BITS + 3;
  localparam int NI = (TRIG_ITERATIONS > MaxIter) ? MaxIter : TRIG_ITERATIONS;
  localparam longint X0L =
    (longint'(InvGainQ30) + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  logic signed [CW-1:0] x, y, dx, dy;
  logic signed [32:0]   z, at;
  logic [4:0]           it;
  logic                 run;
  logic                 flp;

  assign dx = y >>> it;
  assign dy = x >>> it;
  assign at = signed'({3'b000, atan_q30(it)});
  assign sn = flp ? -y : y;
  assign cs = flp ? -x : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x   <= CW'(X0L);
        y   <= '0;
        z   <= signed'(z0);
        flp <= flip;
        it  <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (!z[32]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        it <= it + 5'd1;
        if (it == 5'(NI - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/two_rot.sv =====
`default_nettype none
module two_rot #(
  parameter int FRAC_BITS = two_pkg::FracBits
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [34:0]             v,
  input  wire logic signed [31:0]             hv,
  input  wire logic signed [FRAC_BITS+2:0]    sn,
  input  wire logic signed [FRAC_BITS+2:0]    cs,
  output logic                                done,
  output logic signed [FRAC_BITS+38:0]        accx,
  output logic signed [FRAC_BITS+38:0]        accy
);
  import two_pkg::*;

  localparam int CW = FRAC_BITS + 3;
  localparam int AW = FRAC_BITS + 39;

  logic signed [AW-1:0] vsh, hsh, ax, ay;
  logic [CW-1:0]        snr, csr;
  logic [5:0]           cnt;
  logic                 run;

  assign ax = (snr[0] ? vsh : '0) + (csr[0] ? hsh : '0);
  assign ay = (csr[0] ? vsh : '0) - (snr[0] ? hsh : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        vsh  <= {{(AW-35){v[34]}}, v};
        hsh  <= {{(AW-32){hv[31]}}, hv};
        snr  <= sn;
        csr  <= cs;
        accx <= '0;
        accy <= '0;
        cnt  <= 6'(CW);
        run  <= 1'b1;
      end else if (run) begin
        if (cnt == 6'd1) begin
          accx <= accx - ax;
          accy <= accy - ay;
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          accx <= accx + ax;
          accy <= accy + ay;
        end
        vsh <= vsh <<< 1;
        hsh <= hsh <<< 1;
        snr <= snr >> 1;
        csr <= csr >> 1;
        cnt <= cnt - 6'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tracking_wheel_odometry.sv =====
// Tracking-wheel odometry with an absolute heading source.
// Input channel (in_valid/in_ready/in_data): one beat per sample, carrying the
// gyro heading and both wheel travels; op set loads new_x/new_y first.
// Output channel (out_valid/out_ready/out_data): one beat per input beat with
// the saturated field position and the stored heading.
// cfg_we/cfg_wdata write the vertical wheel offset; write only while idle.
// One sample is processed at a time. Each input beat goes through a
// bit-serial divide for the CORDIC angle, overlapped with the serial
// offset multiply, then the CORDIC loop, a second bit-serial divide for
// the offset term, then a bit-serial rotate before the result is registered.
// A new sample is taken only once the previous one has left the final state.
// The result sits in an output register; a new input beat is taken while it
// waits. If the receiver stalls past the next result, the block holds that
// result in its final state and takes no input until the register frees.
// Reset clears position, heading, offset and both channels.
`default_nettype none
module tracking_wheel_odometry #(
  parameter int FRAC_BITS       = two_pkg::FracBits,
  parameter int TRIG_ITERATIONS = two_pkg::TrigIterations
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire two_pkg::two_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output two_pkg::two_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [31:0]      cfg_wdata
);
  import two_pkg::*;

  localparam int CW = FRAC_BITS + 3;
  localparam int AW = FRAC_BITS + 39;
  localparam int SW = AW - FRAC_BITS + 1;
  localparam int PW = 78;

  two_state_t state, state_next;

  logic signed [31:0] off;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0]        last_heading;
  logic signed [31:0] vert, hori;
  logic [14:0]        dmag;
  logic [13:0]        hmag;
  logic               neg, zneg, flip;

  logic [PW-1:0]      msh, macc;
  logic [31:0]        omr;
  logic [5:0]         mcnt;

  logic               accept;
  logic [15:0]        hm;
  logic signed [16:0] ds, dw, hs, hf;
  logic               fl;

  logic               div_start, div_done;
  logic [63:0]        div_dvd;
  logic [29:0]        div_dsr;
  logic [33:0]        div_q;
  logic               cor_start, cor_done;
  logic [32:0]        zpos, z0;
  logic signed [CW-1:0] sn, cs;
  logic               rot_start, rot_done;
  logic signed [34:0] v;
  logic signed [AW-1:0] accx, accy, rx, ry;
  logic signed [SW-1:0] sumx, sumy;
  logic signed [31:0] nx, ny;
  logic               fin;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    hm = (in_data.heading_in >= FullTurn) ? in_data.heading_in - FullTurn
                                          : in_data.heading_in;
    ds = signed'({1'b0, hm}) - signed'({1'b0, last_heading});
    if (ds > signed'({1'b0, HalfTurn})) begin
      dw = ds - signed'({1'b0, FullTurn});
    end else if (ds <= -signed'({1'b0, HalfTurn})) begin
      dw = ds + signed'({1'b0, FullTurn});
    end else begin
      dw = ds;
    end
    hs = (hm > HalfTurn) ? signed'({1'b0, hm}) - signed'({1'b0, FullTurn})
                         : signed'({1'b0, hm});
    fl = 1'b0;
    if (hs > signed'({1'b0, QuarterTurn})) begin
      hf = hs - signed'({1'b0, HalfTurn});
      fl = 1'b1;
    end else if (hs < -signed'({1'b0, QuarterTurn})) begin
      hf = hs + signed'({1'b0, HalfTurn});
      fl = 1'b1;
    end else begin
      hf = hs;
    end
  end

  assign div_start = (state == S_PREP) || (state == S_TRIG && cor_done);
  always_comb begin
    if (state == S_PREP) begin
      div_dvd = {18'd0, 46'({14'd0, hmag} * {14'd0, PiQ30}) + 46'(QuarterTurn)};
      div_dsr = 30'(HalfTurn);
    end else begin
      div_dvd = {2'b00, macc[PW-1:16]} + {34'd0, OffsetHalf};
      div_dsr = OffsetDen;
    end
  end

  assign zpos      = div_q[32:0];
  assign z0        = zneg ? -zpos : zpos;
  assign cor_start = (state == S_ZDIV) && div_done;
  assign rot_start = (state == S_ODIV) && div_done;
  assign v = {{3{vert[31]}}, vert} + (neg ? -{1'b0, div_q} : {1'b0, div_q});

  two_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  two_cordic #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .z0(z0), .flip(flip),
    .done(cor_done), .sn(sn), .cs(cs)
  );

  two_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk(clk), .rst(rst), .start(rot_start), .v(v), .hv(hori), .sn(sn), .cs(cs),
    .done(rot_done), .accx(accx), .accy(accy)
  );

  always_comb begin
    rx   = accx + (AW'(1) <<< (FRAC_BITS - 1));
    ry   = accy + (AW'(1) <<< (FRAC_BITS - 1));
    sumx = {{(SW-32){pos_x[31]}}, pos_x} + {rx[AW-1], rx[AW-1:FRAC_BITS]};
    sumy = {{(SW-32){pos_y[31]}}, pos_y} + {ry[AW-1], ry[AW-1:FRAC_BITS]};
    if (sumx[SW-1:31] != {(SW-31){sumx[31]}}) begin
      nx = sumx[SW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      nx = sumx[31:0];
    end
    if (sumy[SW-1:31] != {(SW-31){sumy[31]}}) begin
      ny = sumy[SW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      ny = sumy[31:0];
    end
  end

  assign fin = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_PREP;
      S_PREP: state_next = S_ZDIV;
      S_ZDIV: if (div_done) state_next = S_TRIG;
      S_TRIG: if (cor_done) state_next = S_ODIV;
      S_ODIV: if (div_done) state_next = S_ROT;
      S_ROT:  if (rot_done) state_next = S_FIN;
      S_FIN:  if (fin) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off          <= '0;
      pos_x        <= '0;
      pos_y        <= '0;
      last_heading <= '0;
      out_valid    <= 1'b0;
      mcnt         <= '0;
    end else begin
      if (cfg_we) begin
        off <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (in_data.op == OP_SET) begin
          pos_x <= in_data.new_x;
          pos_y <= in_data.new_y;
        end
        last_heading <= hm;
        vert <= in_data.vert_delta;
        hori <= in_data.hori_delta;
        dmag <= dw[16] ? 15'(-dw) : dw[14:0];
        hmag <= hf[16] ? 14'(-hf) : hf[13:0];
        zneg <= hf[16];
        flip <= fl;
        neg  <= off[31] != dw[16];
      end
      if (state == S_PREP) begin
        msh  <= {31'd0, 47'({32'd0, dmag} * {15'd0, PiQ30})};
        macc <= '0;
        omr  <= off[31] ? 32'(-off) : off;
        mcnt <= 6'd32;
      end else if (mcnt != 6'd0) begin
        if (omr[0]) begin
          macc <= macc + msh;
        end
        msh  <= msh << 1;
        omr  <= omr >> 1;
        mcnt <= mcnt - 6'd1;
      end
      if (fin) begin
        pos_x     <= nx;
        pos_y     <= ny;
        out_valid <= 1'b1;
        out_data.x_out       <= nx;
        out_data.y_out       <= ny;
        out_data.heading_out <= last_heading;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input beat taken while a sample is in flight");

  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid && state == S_IDLE)
    else $error("finished sample did not reach the output register");

  a_cordic_phase: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == S_TRIG)
    else $error("trig result outside its phase");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.heading_out < FullTurn)
    else $error("stored heading out of range");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import two_pkg::*;

  localparam int NumRandom = 1600;
  localparam int Latency   = 2 * 34 + TrigIterations + FracBits + 11;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  two_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  two_out_t out_data;
  logic     cfg_we;
  logic [31:0] cfg_wdata;

  tracking_wheel_odometry u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  two_in_t  sample_q[$];
  two_out_t pose_q[$];
  int       errors;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  int       stall_phase;
  bit       hold_req;

  longint   odo_x;
  longint   odo_y;
  int       odo_heading;
  longint   wheel_offset;

  localparam longint AtanTab[MaxIter] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127
  };

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint offset_turn(longint off, longint d);
    bit     neg;
    longint unsigned p;
    longint unsigned s;
    longint unsigned den;
    longint r;
    neg = (off < 0) != (d < 0);
    p = longint'(off < 0 ? -off : off) * longint'(d < 0 ? -d : d);
    s = p * (PiQ30 >> 16) + ((p * (PiQ30 & 32'hFFFF)) >> 16);
    den = longint'(FullTurn) << 14;
    r = longint'((s + den / 2) / den);
    return neg ? -r : r;
  endfunction

  task automatic heading_trig(input int hd, output longint sn, output longint cs);
    bit     flip;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int     n;
    flip = 0;
    if (hd > int'(HalfTurn)) hd -= int'(FullTurn);
    if (hd > int'(QuarterTurn)) begin
      hd -= int'(HalfTurn);
      flip = 1;
    end else if (hd < -int'(QuarterTurn)) begin
      hd += int'(HalfTurn);
      flip = 1;
    end
    z = (longint'(hd < 0 ? -hd : hd) * longint'(PiQ30) + HalfTurn / 2) / HalfTurn;
    if (hd < 0) z = -z;
    x = (longint'(InvGainQ30) + (64'sd1 << (29 - FracBits))) >>> (30 - FracBits);
    y = 0;
    n = TrigIterations > MaxIter ? MaxIter : TrigIterations;
    for (int i = 0; i < n; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  task automatic predict_pose(input two_in_t s);
    int       hd;
    longint   d;
    longint   vert;
    longint   hori;
    longint   sn;
    longint   cs;
    two_out_t p;
    hd = int'(s.heading_in) % int'(FullTurn);
    vert = longint'($signed(s.vert_delta));
    hori = longint'($signed(s.hori_delta));
    if (s.op == OP_SET) begin
      odo_x = longint'($signed(s.new_x));
      odo_y = longint'($signed(s.new_y));
    end
    d = hd - odo_heading;
    if (d > longint'(HalfTurn)) d -= longint'(FullTurn);
    else if (d <= -longint'(HalfTurn)) d += longint'(FullTurn);
    odo_heading = hd;
    vert += offset_turn(wheel_offset, d);
    heading_trig(hd, sn, cs);
    odo_x = clamp32(odo_x + ((vert * sn + hori * cs + (64'sd1 << (FracBits - 1)))
                             >>> FracBits));
    odo_y = clamp32(odo_y + ((vert * cs - hori * sn + (64'sd1 << (FracBits - 1)))
                             >>> FracBits));
    p.x_out = odo_x[31:0];
    p.y_out = odo_y[31:0];
    p.heading_out = odo_heading[15:0];
    pose_q.push_back(p);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) predict_pose(in_data);
      if (gap_left > 0) begin
        in_valid <= 0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() > 0) begin
        in_valid <= 1;
        in_data <= sample_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(150, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    two_out_t want;
    if (rst) begin
      out_ready <= 0;
      hold_left <= 0;
      stall_phase <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          report("extra beat", out_data.x_out, 32'd0);
        end else begin
          want = pose_q.pop_front();
          if (out_data.x_out !== want.x_out) report("x", out_data.x_out, want.x_out);
          if (out_data.y_out !== want.y_out) report("y", out_data.y_out, want.y_out);
          if (out_data.heading_out !== want.heading_out)
            report("heading", 32'(out_data.heading_out), 32'(want.heading_out));
        end
      end
      stall_phase <= (stall_phase + 1) % 1000;
      if (hold_req && hold_left == 0) begin
        hold_left <= 2000;
        out_ready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (stall_phase < 400) begin
        out_ready <= 1;
      end else begin
        out_ready <= ($urandom_range(3, 0) != 0) && (stall_phase % 97 < 60);
      end
    end
  end

  function automatic two_in_t rand_sample(bit wellformed);
    two_in_t s;
    s.op = ($urandom_range(9, 0) == 0) ? OP_SET : OP_SAMPLE;
    s.heading_in = wellformed ? 16'($urandom_range(35999, 0)) : 16'($urandom);
    case ($urandom_range(3, 0))
      0: begin
        s.vert_delta = $urandom;
        s.hori_delta = $urandom;
      end
      1: begin
        s.vert_delta = 32'($signed(17'($urandom)));
        s.hori_delta = 32'($signed(17'($urandom)));
      end
      default: begin
        s.vert_delta = 32'($signed(20'($urandom)));
        s.hori_delta = 32'($signed(20'($urandom)));
      end
    endcase
    s.new_x = ($urandom_range(1, 0) == 0) ? $urandom : 32'($signed(24'($urandom)));
    s.new_y = ($urandom_range(1, 0) == 0) ? $urandom : 32'($signed(24'($urandom)));
    return s;
  endfunction

  task automatic drain();
    while (sample_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
  endtask

  task automatic set_offset(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    wheel_offset = longint'($signed(v));
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic two_in_t fixed_sample(two_op_t op, int hd, logic [31:0] v,
                                           logic [31:0] h, logic [31:0] nx,
                                           logic [31:0] ny);
    two_in_t s;
    s.op = op;
    s.heading_in = 16'(hd);
    s.vert_delta = v;
    s.hori_delta = h;
    s.new_x = nx;
    s.new_y = ny;
    return s;
  endfunction

  logic [31:0] offsets[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0006_8000,
                              32'hFFFE_0000, 32'h0000_0000};

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    hold_req = 0;
    errors = 0;
    odo_x = 0;
    odo_y = 0;
    odo_heading = 0;
    wheel_offset = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    set_offset(32'h0004_0000);
    sample_q.push_back(fixed_sample(OP_SAMPLE, 0, 32'h0001_0000, 0, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 9000, 32'h0001_0000, 32'h0002_0000, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 27000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 9000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 35999, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 17999, 32'h0000_8000, 0, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 65535, 0, 0, 0, 0));
    sample_q.push_back(fixed_sample(OP_SET, 36000, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 18000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 0, 32'h8000_0000, 32'h8000_0000, 0, 0));
    sample_q.push_back(fixed_sample(OP_SET, 18000, 32'h0001_0000, 0, 32'h8000_0000,
                                    32'h7FFF_FFFF));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 0, 0, 32'h0001_0000, 0, 0));
    sample_q.push_back(fixed_sample(OP_SET, 4500, 32'h0003_0000, 32'hFFFD_0000, 0, 0));
    sample_q.push_back(fixed_sample(OP_SAMPLE, 13500, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    foreach (offsets[k]) begin
      set_offset(offsets[k]);
      if (k == 1) hold_req = 1;
      for (int i = 0; i < NumRandom / 5; i++)
        sample_q.push_back(rand_sample($urandom_range(7, 0) != 0));
      if (k == 1) begin
        repeat (20) @(posedge clk);
        hold_req = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
